// File: src/ttce_pkg.sv
// shared types and constants of the text terminal character engine
`timescale 1ns / 1ps

package ttce_pkg;

    // cell address width, wide enough for the largest screen the cursor fields can name (32 x 128 cells)
    localparam int ADDR_W = 16;

    typedef logic [6:0]        t_col;
    typedef logic [4:0]        t_row;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [2:0] {
        FUNC_PUT   = 3'd0,
        FUNC_LEFT  = 3'd1,
        FUNC_RIGHT = 3'd2,
        FUNC_UP    = 3'd3,
        FUNC_DOWN  = 3'd4,
        FUNC_READ  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        CFG_PEN_RED   = 2'd0,
        CFG_PEN_GREEN = 2'd1,
        CFG_PEN_BLUE  = 2'd2
    } t_cfg_reg;

    localparam logic [7:0] CHAR_CLEAR     = 8'd12;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;

    localparam logic [7:0] RESET_RED   = 8'd255;
    localparam logic [7:0] RESET_GREEN = 8'd255;
    localparam logic [7:0] RESET_BLUE  = 8'd0;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    typedef struct packed {
        t_col       cursor_col;
        t_row       cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_red;
        logic [7:0] cell_green;
        logic [7:0] cell_blue;
    } t_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef struct packed {
        logic [7:0] ch;
        t_color     color;
    } t_cell;

    // one job for the cell engine: copy, then fill, then optional read
    typedef struct packed {
        t_addr      copy_lo;
        t_addr      copy_hi;
        logic       copy_by_row;
        t_addr      fill_lo;
        t_addr      fill_hi;
        logic [7:0] fill_char;
        logic       is_read;
        logic       read_ok;
        t_addr      read_addr;
        logic       reply;
        t_col       cursor_col;
        t_row       cursor_row;
    } t_cmd;

endpackage

// File: src/text_terminal_char_engine.sv
// top level of the text terminal character engine: pen registers, front end, job queue, cell engine
`timescale 1ns / 1ps

// Character engine of a glass-tty style terminal with a ROWS x COLUMNS screen of
// characters and 24-bit colors. Each request returns one result with the cursor
// position after the request and, for a cell read, the cell contents. Cursor
// moves and the other requests that leave the screen alone touch no cell; put char
// and cell read touch one cell; a backspace inside a row moves the rest of the
// row; a clear, or any request that scrolls the screen, sweeps every cell, after
// the character when one goes into the bottom-right cell just before the scroll.
// The cell memory moves one cell per cycle. The front end keeps the cursor and
// runs ahead of the cell engine by up to two queued jobs. After reset the engine
// blanks every cell to a space in the reset pen color; requests stall during
// that pass, pen register writes are taken.
module text_terminal_char_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ttce_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output ttce_pkg::t_out  o_out_data,
    input  logic            i_out_stall,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data
);

    ttce_pkg::t_color r_pen;
    logic             init_busy;
    logic             queue_full;
    logic             queue_empty;
    logic             push;
    logic             pop;
    ttce_pkg::t_cmd   push_data;
    ttce_pkg::t_cmd   head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen.red   <= ttce_pkg::RESET_RED;
            r_pen.green <= ttce_pkg::RESET_GREEN;
            r_pen.blue  <= ttce_pkg::RESET_BLUE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ttce_pkg::CFG_PEN_RED:   r_pen.red   <= i_cfg_data;
                ttce_pkg::CFG_PEN_GREEN: r_pen.green <= i_cfg_data;
                ttce_pkg::CFG_PEN_BLUE:  r_pen.blue  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ttce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_init_busy  (init_busy),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    ttce_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (queue_empty)
    );

    ttce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pen       (r_pen),
        .i_empty     (queue_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: src/ttce_cmd_queue.sv
// two-entry job queue between the cursor front end and the cell engine
`timescale 1ns / 1ps

module ttce_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ttce_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output ttce_pkg::t_cmd  o_head,
    output logic            o_empty
);

    ttce_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: src/ttce_front.sv
// front end: takes requests, keeps the cursor and turns requests into cell jobs
`timescale 1ns / 1ps

module ttce_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ttce_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    input  logic            i_init_busy,
    input  logic            i_queue_full,
    output logic            o_push,
    output ttce_pkg::t_cmd  o_push_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int NW    = $clog2(CELLS + 1);

    localparam logic [NW-1:0] COLS_N    = NW'(COLUMNS);
    localparam logic [NW-1:0] CELLS_N   = NW'(CELLS);
    localparam logic [NW-1:0] LAST_BASE = NW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] X_LAST    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] Y_LAST    = RW'(ROWS - 1);

    typedef enum logic [1:0] {
        F_RUN    = 2'b01,
        F_SECOND = 2'b10
    } t_front_state;

    t_front_state   r_state, n_state;
    logic [CW-1:0]  r_x, n_x;
    logic [RW-1:0]  r_y, n_y;
    logic [NW-1:0]  r_base, n_base;   // r_y * COLUMNS, kept alongside the cursor
    ttce_pkg::t_cmd r_second, n_second;

    logic           accept;
    logic           at_last_col;
    logic           at_last_row;
    logic [RW-1:0]  down_y;
    logic [NW-1:0]  down_base;
    logic [NW-1:0]  up_base;
    logic [NW-1:0]  cur_addr;
    logic [NW-1:0]  rd_addr;
    logic           rd_ok;
    logic           do_scroll;
    logic           has_write;
    ttce_pkg::t_cmd mem_cmd;
    ttce_pkg::t_cmd scroll_cmd;
    ttce_pkg::t_cmd first_cmd;

    assign o_in_stall  = i_init_busy || i_queue_full || (r_state == F_SECOND);
    assign accept      = i_in_valid && !o_in_stall;

    assign at_last_col = (r_x == X_LAST);
    assign at_last_row = (r_y == Y_LAST);
    assign down_y      = at_last_row ? r_y : r_y + RW'(1);
    assign down_base   = at_last_row ? r_base : r_base + COLS_N;
    assign up_base     = r_base - COLS_N;
    assign cur_addr    = r_base + NW'(r_x);

    assign rd_ok   = (int'(i_in_data.read_row) < ROWS) && (int'(i_in_data.read_col) < COLUMNS);
    assign rd_addr = NW'(NW'(i_in_data.read_row) * COLS_N + NW'(i_in_data.read_col));

    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        n_base    = r_base;
        do_scroll = 1'b0;
        has_write = 1'b0;

        mem_cmd             = '0;
        mem_cmd.fill_char   = ttce_pkg::CHAR_SPACE;
        mem_cmd.reply       = 1'b1;

        case (i_in_data.func)
            ttce_pkg::FUNC_PUT: begin
                case (i_in_data.char_code)
                    ttce_pkg::CHAR_CLEAR: begin
                        n_x             = '0;
                        n_y             = '0;
                        n_base          = '0;
                        mem_cmd.fill_hi = ttce_pkg::t_addr'(CELLS_N);
                    end
                    ttce_pkg::CHAR_NEWLINE: begin
                        n_x       = '0;
                        n_y       = down_y;
                        n_base    = down_base;
                        do_scroll = at_last_row;
                    end
                    ttce_pkg::CHAR_BACKSPACE: begin
                        if (r_x != '0) begin
                            // pull the rest of the row one place left, blank the row end
                            n_x                 = r_x - CW'(1);
                            mem_cmd.copy_lo     = ttce_pkg::t_addr'(cur_addr - NW'(1));
                            mem_cmd.copy_hi     = ttce_pkg::t_addr'(r_base + COLS_N - NW'(1));
                            mem_cmd.fill_lo     = ttce_pkg::t_addr'(r_base + COLS_N - NW'(1));
                            mem_cmd.fill_hi     = ttce_pkg::t_addr'(r_base + COLS_N);
                        end else if (r_y != '0) begin
                            n_x             = X_LAST;
                            n_y             = r_y - RW'(1);
                            n_base          = up_base;
                            mem_cmd.fill_lo = ttce_pkg::t_addr'(r_base - NW'(1));
                            mem_cmd.fill_hi = ttce_pkg::t_addr'(r_base);
                        end else begin
                            mem_cmd.fill_lo = '0;
                            mem_cmd.fill_hi = ttce_pkg::t_addr'(1);
                        end
                    end
                    default: begin
                        has_write         = 1'b1;
                        mem_cmd.fill_lo   = ttce_pkg::t_addr'(cur_addr);
                        mem_cmd.fill_hi   = ttce_pkg::t_addr'(cur_addr + NW'(1));
                        mem_cmd.fill_char = i_in_data.char_code;
                        if (at_last_col) begin
                            n_x       = '0;
                            n_y       = down_y;
                            n_base    = down_base;
                            do_scroll = at_last_row;
                        end else begin
                            n_x = r_x + CW'(1);
                        end
                    end
                endcase
            end
            ttce_pkg::FUNC_LEFT: begin
                if (r_x != '0) begin
                    n_x = r_x - CW'(1);
                end else if (r_y != '0) begin
                    n_x    = X_LAST;
                    n_y    = r_y - RW'(1);
                    n_base = up_base;
                end
            end
            ttce_pkg::FUNC_RIGHT: begin
                if (at_last_col) begin
                    n_x       = '0;
                    n_y       = down_y;
                    n_base    = down_base;
                    do_scroll = at_last_row;
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            ttce_pkg::FUNC_UP: begin
                if (r_y != '0) begin
                    n_y    = r_y - RW'(1);
                    n_base = up_base;
                end
            end
            ttce_pkg::FUNC_DOWN: begin
                n_y       = down_y;
                n_base    = down_base;
                do_scroll = at_last_row;
            end
            ttce_pkg::FUNC_READ: begin
                mem_cmd.is_read   = 1'b1;
                mem_cmd.read_ok   = rd_ok;
                mem_cmd.read_addr = ttce_pkg::t_addr'(rd_addr);
            end
            default: begin
            end
        endcase

        mem_cmd.cursor_col = ttce_pkg::t_col'(n_x);
        mem_cmd.cursor_row = ttce_pkg::t_row'(n_y);

        scroll_cmd             = mem_cmd;
        scroll_cmd.copy_lo     = '0;
        scroll_cmd.copy_hi     = ttce_pkg::t_addr'(LAST_BASE);
        scroll_cmd.copy_by_row = 1'b1;
        scroll_cmd.fill_lo     = ttce_pkg::t_addr'(LAST_BASE);
        scroll_cmd.fill_hi     = ttce_pkg::t_addr'(CELLS_N);
        scroll_cmd.fill_char   = ttce_pkg::CHAR_SPACE;
        scroll_cmd.reply       = 1'b1;

        // a character written in the bottom-right cell goes in before the scroll
        first_cmd = mem_cmd;
        n_second  = r_second;
        if (do_scroll && has_write) begin
            first_cmd.reply = 1'b0;
            n_second        = scroll_cmd;
        end else if (do_scroll) begin
            first_cmd = scroll_cmd;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_push      = 1'b0;
        o_push_data = first_cmd;
        case (r_state)
            F_RUN: begin
                if (accept) begin
                    o_push = 1'b1;
                    if (do_scroll && has_write) begin
                        n_state = F_SECOND;
                    end
                end
            end
            F_SECOND: begin
                o_push_data = r_second;
                if (!i_queue_full) begin
                    o_push  = 1'b1;
                    n_state = F_RUN;
                end
            end
            default: begin
                n_state = F_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_RUN;
            r_x     <= '0;
            r_y     <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_base <= n_base;
            end
        end
    end

endmodule

// File: src/ttce_back.sv
// cell engine: character and color memory, copy and fill sweeps, cell reads, result register
`timescale 1ns / 1ps

module ttce_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttce_pkg::t_color  i_pen,
    input  logic              i_empty,
    input  ttce_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_init_busy,
    output logic              o_out_valid,
    output ttce_pkg::t_out    o_out_data,
    input  logic              i_out_stall
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);

    localparam logic [NW-1:0] COLS_N   = NW'(COLUMNS);
    localparam logic [NW-1:0] LAST_IDX = NW'(CELLS - 1);

    typedef enum logic [5:0] {
        B_INIT = 6'b000001,
        B_IDLE = 6'b000010,
        B_COPY = 6'b000100,
        B_FILL = 6'b001000,
        B_READ = 6'b010000,
        B_DONE = 6'b100000
    } t_back_state;

    ttce_pkg::t_cell r_mem [CELLS];
    ttce_pkg::t_cell r_rd;

    t_back_state     r_state, n_state;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic            r_wr_pend, n_wr_pend;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    ttce_pkg::t_cmd  r_cmd;
    logic            r_out_valid;
    ttce_pkg::t_out  r_out;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    ttce_pkg::t_cell mem_wd;
    logic            mem_re;
    logic [AW-1:0]   mem_ra;
    logic [NW-1:0]   src_addr;
    logic            out_free;
    logic            emit;

    assign o_init_busy = (r_state == B_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign src_addr    = r_cnt + (r_cmd.copy_by_row ? COLS_N : NW'(1));

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_wr_pend = 1'b0;
        n_wr_addr = r_wr_addr;
        mem_we    = 1'b0;
        mem_wa    = r_wr_addr;
        mem_wd    = r_rd;
        mem_re    = 1'b0;
        mem_ra    = src_addr[AW-1:0];
        o_pop     = 1'b0;
        emit      = 1'b0;

        case (r_state)
            B_INIT: begin
                mem_we         = 1'b1;
                mem_wa         = r_cnt[AW-1:0];
                mem_wd.ch      = ttce_pkg::CHAR_SPACE;
                mem_wd.color   = {ttce_pkg::RESET_RED, ttce_pkg::RESET_GREEN,
                                  ttce_pkg::RESET_BLUE};
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = B_IDLE;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cnt   = NW'(i_head.copy_lo);
                    n_state = B_COPY;
                end
            end
            B_COPY: begin
                // read the source cell (one cell or one row ahead), write it to the current cell in the next cycle
                if (r_wr_pend) begin
                    mem_we = 1'b1;
                end
                if (r_cnt != NW'(r_cmd.copy_hi)) begin
                    mem_re    = 1'b1;
                    n_wr_addr = r_cnt[AW-1:0];
                    n_wr_pend = 1'b1;
                    n_cnt     = r_cnt + NW'(1);
                end else if (!r_wr_pend) begin
                    n_cnt   = NW'(r_cmd.fill_lo);
                    n_state = B_FILL;
                end
            end
            B_FILL: begin
                if (r_cnt != NW'(r_cmd.fill_hi)) begin
                    mem_we       = 1'b1;
                    mem_wa       = r_cnt[AW-1:0];
                    mem_wd.ch    = r_cmd.fill_char;
                    mem_wd.color = i_pen;
                    n_cnt        = r_cnt + NW'(1);
                end else if (r_cmd.is_read) begin
                    n_state = B_READ;
                end else begin
                    n_state = B_DONE;
                end
            end
            B_READ: begin
                // out-of-range reads leave the memory alone
                mem_re  = r_cmd.read_ok;
                mem_ra  = r_cmd.read_addr[AW-1:0];
                n_state = B_DONE;
            end
            B_DONE: begin
                if (!r_cmd.reply) begin
                    n_state = B_IDLE;
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (emit) begin
            r_out.cursor_col <= r_cmd.cursor_col;
            r_out.cursor_row <= r_cmd.cursor_row;
            if (r_cmd.is_read && r_cmd.read_ok) begin
                r_out.cell_char  <= r_rd.ch;
                r_out.cell_red   <= r_rd.color.red;
                r_out.cell_green <= r_rd.color.green;
                r_out.cell_blue  <= r_rd.color.blue;
            end else begin
                r_out.cell_char  <= '0;
                r_out.cell_red   <= '0;
                r_out.cell_green <= '0;
                r_out.cell_blue  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_cnt       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_wr_pend <= n_wr_pend;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: sim/tb_text_terminal_char_engine.sv
// self-checking testbench of the text terminal character engine
`timescale 1ns / 1ps

module tb_text_terminal_char_engine;

    localparam int COLS        = 80;
    localparam int ROWS        = 24;
    localparam int CELLS       = COLS * ROWS;
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 50;

    // func codes the block leaves unused
    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    ttce_pkg::t_in   in_data   = '0;
    logic            in_stall;
    logic            out_valid;
    ttce_pkg::t_out  out_data;
    logic            out_stall = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = '0;
    logic [7:0]      cfg_data  = '0;

    // predicted screen, pen and cursor
    ttce_pkg::t_cell  screen [CELLS];
    ttce_pkg::t_color pen;
    int               cur_col;
    int               cur_row;

    ttce_pkg::t_out predicted_replies [$];
    int             errors       = 0;
    int             reqs_sent    = 0;
    int             quiet_cycles = 0;

    text_terminal_char_engine #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog, nothing moved for %0d cycles", $time, QUIET_LIMIT);
                $display("[text_terminal_char_engine] ERROR");
                $finish;
            end
        end
    end

    function automatic void blank_cell(int idx);
        screen[idx].ch    = ttce_pkg::CHAR_SPACE;
        screen[idx].color = pen;
    endfunction

    function automatic void clear_screen();
        for (int i = 0; i < CELLS; i++)
            blank_cell(i);
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic void cursor_down();
        if (cur_row == ROWS - 1) begin
            // scroll up one line, bottom line blank in the pen color
            for (int i = 0; i < CELLS - COLS; i++)
                screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                blank_cell(i);
        end else begin
            cur_row++;
        end
    endfunction

    function automatic void cursor_right();
        cur_col++;
        if (cur_col == COLS) begin
            cur_col = 0;
            cursor_down();
        end
    endfunction

    function automatic void cursor_left();
        if (cur_col > 0) begin
            cur_col--;
        end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
        end
    endfunction

    function automatic ttce_pkg::t_out terminal_step(ttce_pkg::t_in req);
        ttce_pkg::t_out res;
        int             base;
        int             idx;
        res  = '0;
        base = cur_row * COLS;
        case (req.func)
            ttce_pkg::FUNC_PUT: begin
                if (req.char_code == ttce_pkg::CHAR_CLEAR) begin
                    clear_screen();
                end else if (req.char_code == ttce_pkg::CHAR_NEWLINE) begin
                    cur_col = 0;
                    cursor_down();
                end else if (req.char_code == ttce_pkg::CHAR_BACKSPACE) begin
                    if (cur_col == 0) begin
                        // rub out across the line break, (0,0) just gets blanked
                        cursor_left();
                        blank_cell(cur_row * COLS + cur_col);
                    end else begin
                        cur_col--;
                        for (int x = cur_col; x < COLS - 1; x++)
                            screen[base + x] = screen[base + x + 1];
                        blank_cell(base + COLS - 1);
                    end
                end else begin
                    screen[base + cur_col].ch    = req.char_code;
                    screen[base + cur_col].color = pen;
                    cursor_right();
                end
            end
            ttce_pkg::FUNC_LEFT:  cursor_left();
            ttce_pkg::FUNC_RIGHT: cursor_right();
            ttce_pkg::FUNC_UP: begin
                if (cur_row > 0)
                    cur_row--;
            end
            ttce_pkg::FUNC_DOWN:  cursor_down();
            ttce_pkg::FUNC_READ: begin
                if (req.read_row < ROWS && req.read_col < COLS) begin
                    idx            = req.read_row * COLS + req.read_col;
                    res.cell_char  = screen[idx].ch;
                    res.cell_red   = screen[idx].color.red;
                    res.cell_green = screen[idx].color.green;
                    res.cell_blue  = screen[idx].color.blue;
                end
            end
            default: ;
        endcase
        res.cursor_col = ttce_pkg::t_col'(cur_col);
        res.cursor_row = ttce_pkg::t_row'(cur_row);
        return res;
    endfunction

    function automatic ttce_pkg::t_in make_req(logic [2:0] func, logic [7:0] code,
                                               int row, int col);
        ttce_pkg::t_in req;
        req.func      = func;
        req.char_code = code;
        req.read_row  = 5'(row);
        req.read_col  = 7'(col);
        return req;
    endfunction

    // character codes 13 to 255, never one of the control codes
    function automatic logic [7:0] text_char();
        return 8'($urandom_range(13, 255));
    endfunction

    function automatic ttce_pkg::t_in random_req();
        ttce_pkg::t_in req;
        int            pick;
        req.func      = ttce_pkg::FUNC_PUT;
        req.char_code = 8'($urandom_range(0, 255));
        req.read_row  = 5'($urandom_range(0, 31));
        req.read_col  = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            req.func = ttce_pkg::FUNC_PUT;
        end else if (pick < 53) begin
            req.char_code = ttce_pkg::CHAR_NEWLINE;
        end else if (pick < 60) begin
            req.char_code = ttce_pkg::CHAR_BACKSPACE;
        end else if (pick < 61) begin
            req.char_code = ttce_pkg::CHAR_CLEAR;
        end else if (pick < 66) begin
            req.func = ttce_pkg::FUNC_LEFT;
        end else if (pick < 71) begin
            req.func = ttce_pkg::FUNC_RIGHT;
        end else if (pick < 76) begin
            req.func = ttce_pkg::FUNC_UP;
        end else if (pick < 81) begin
            req.func = ttce_pkg::FUNC_DOWN;
        end else if (pick < 97) begin
            req.func = ttce_pkg::FUNC_READ;
            if ($urandom_range(0, 5) != 0) begin
                req.read_row = 5'($urandom_range(0, ROWS - 1));
                req.read_col = 7'($urandom_range(0, COLS - 1));
            end
        end else begin
            req.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        end
        return req;
    endfunction

    task automatic send_req(ttce_pkg::t_in req);
        int gap;
        gap = $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted_replies.push_back(terminal_step(req));
        reqs_sent++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_pen(ttce_pkg::t_color c);
        ttce_pkg::t_cfg_reg regs [3];
        logic [7:0]         vals [3];
        regs = '{ttce_pkg::CFG_PEN_RED, ttce_pkg::CFG_PEN_GREEN, ttce_pkg::CFG_PEN_BLUE};
        vals = '{c.red, c.green, c.blue};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
        pen = c;
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    initial begin : result_checker
        int             hold;
        ttce_pkg::t_out want;
        forever begin
            hold = $urandom_range(0, 15);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (predicted_replies.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, actual %p",
                         $time, out_data);
                errors++;
            end else begin
                want = predicted_replies.pop_front();
                check_field("cursor_col", 8'(want.cursor_col), 8'(out_data.cursor_col));
                check_field("cursor_row", 8'(want.cursor_row), 8'(out_data.cursor_row));
                check_field("cell_char", want.cell_char, out_data.cell_char);
                check_field("cell_red", want.cell_red, out_data.cell_red);
                check_field("cell_green", want.cell_green, out_data.cell_green);
                check_field("cell_blue", want.cell_blue, out_data.cell_blue);
            end
        end
    end

    task automatic test_reset_screen();
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, ROWS - 1, COLS - 1));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, ROWS, 0));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, 0, COLS));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'hFF, 31, 127));
        wait_results();
    endtask

    task automatic test_put_and_rubout();
        set_pen('{8'h00, 8'h00, 8'h00});
        send_req(make_req(ttce_pkg::FUNC_PUT, 8'h41, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, 8'hFF, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, 0, 2));
        send_req(make_req(ttce_pkg::FUNC_LEFT, 8'h00, 0, 0));
        // backspace inside a row pulls the tail left
        send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_BACKSPACE, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, 0, 1));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, 0, COLS - 1));
        wait_results();
    endtask

    task automatic test_cursor_wrap();
        send_req(make_req(ttce_pkg::FUNC_UP, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_LEFT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_LEFT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_BACKSPACE, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_DOWN, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_LEFT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_RIGHT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_BACKSPACE, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_NEWLINE, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_CLEAR, 0, 0));
        send_req(make_req(FUNC_SPARE_LO, 8'h00, 0, 0));
        send_req(make_req(FUNC_SPARE_HI, 8'hFF, 31, 127));
        wait_results();
    endtask

    task automatic test_bottom_row();
        set_pen('{8'hFF, 8'hFF, 8'hFF});
        for (int r = 0; r < ROWS - 1; r++) begin
            repeat ($urandom_range(0, 2))
                send_req(make_req(ttce_pkg::FUNC_PUT, text_char(), 0, 0));
            send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_NEWLINE, 0, 0));
        end
        send_req(make_req(ttce_pkg::FUNC_PUT, text_char(), 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_NEWLINE, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_DOWN, 8'h00, 0, 0));
        // hop to the last column of the last row
        send_req(make_req(ttce_pkg::FUNC_LEFT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_DOWN, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, text_char(), 0, 0));
        send_req(make_req(ttce_pkg::FUNC_LEFT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_DOWN, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_RIGHT, 8'h00, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_BACKSPACE, 0, 0));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, ROWS - 2, COLS - 1));
        send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, ROWS - 3, COLS - 1));
        for (int i = 0; i < 4; i++)
            send_req(make_req(ttce_pkg::FUNC_READ, 8'h00, $urandom_range(ROWS - 3, ROWS - 1),
                              $urandom_range(0, COLS - 1)));
        wait_results();
    endtask

    task automatic test_random_traffic();
        int               first;
        ttce_pkg::t_color c;
        for (int phase = 0; phase < 6; phase++) begin
            c.red   = 8'($urandom_range(0, 255));
            c.green = 8'($urandom_range(0, 255));
            c.blue  = 8'($urandom_range(0, 255));
            set_pen(c);
            first   = reqs_sent;
            while (reqs_sent - first < 30) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // run of short lines, often down into scrolling
                        repeat ($urandom_range(1, ROWS)) begin
                            if ($urandom_range(0, 1))
                                send_req(make_req(ttce_pkg::FUNC_PUT, text_char(), 0, 0));
                            send_req(make_req(ttce_pkg::FUNC_PUT, ttce_pkg::CHAR_NEWLINE,
                                              0, 0));
                        end
                    end
                    1: begin
                        send_req(make_req(ttce_pkg::FUNC_LEFT, 8'h00, 0, 0));
                        send_req(make_req(ttce_pkg::FUNC_DOWN, 8'h00, 0, 0));
                        if ($urandom_range(0, 1))
                            send_req(make_req(ttce_pkg::FUNC_RIGHT, 8'h00, 0, 0));
                        else
                            send_req(make_req(ttce_pkg::FUNC_PUT, text_char(), 0, 0));
                    end
                    default: send_req(random_req());
                endcase
            end
            wait_results();
        end
    endtask

    initial begin
        pen = '{ttce_pkg::RESET_RED, ttce_pkg::RESET_GREEN, ttce_pkg::RESET_BLUE};
        clear_screen();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_screen();
        test_put_and_rubout();
        test_cursor_wrap();
        test_bottom_row();
        test_random_traffic();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("[text_terminal_char_engine] OK");
        end else begin
            $display("[text_terminal_char_engine] ERROR");
        end
        $finish;
    end

endmodule
